FILE: src/wdt_pkg.sv
`default_nettype none

package wdt_pkg;

  // Operation codes carried by the opcode field.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  // Word indexes of the register map.
  typedef enum logic [2:0] {
    REG_CTRL   = 3'd0,
    REG_LOAD   = 3'd1,
    REG_COUNT  = 3'd2,
    REG_KEY    = 3'd3,
    REG_STATUS = 3'd4
  } reg_idx_t;

  // Magic values for the key register.
  localparam logic [31:0] FEED_KEY = 32'd1515870810;
  localparam logic [31:0] LOCK_KEY = 32'd443338065;

  // Bit positions within control and status.
  localparam int unsigned CTRL_EN_BIT    = 0;
  localparam int unsigned CTRL_INTEN_BIT = 1;
  localparam int unsigned SR_TIMEOUT_BIT = 0;

  // One input word as held in the input register.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } wdt_item_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        bad_access;
  } wdt_result_t;

endpackage

`default_nettype wire

FILE: src/wdt_ifs.sv
`default_nettype none

// Input channel: one tick, read, write or idle per word.
interface wdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, output opcode, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input reg_index, input write_data,
                  output ready);
endinterface

// Result channel: one result word per input word.
interface wdt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic        bad_access;

  modport source (output valid, output read_data, output irq_level, output bad_access,
                  input ready);
  modport sink   (input valid, input read_data, input irq_level, input bad_access,
                  output ready);
endinterface

`default_nettype wire

FILE: src/wdt_core.sv
`default_nettype none

module wdt_core
  import wdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire wdt_item_t   item,
  output wdt_result_t      result
);

  logic        enable_r,  enable_nxt;
  logic        irq_en_r,  irq_en_nxt;
  logic [31:0] reload_r,  reload_nxt;
  logic [31:0] count_r,   count_nxt;
  logic        timeout_r, timeout_nxt;
  logic        lock_r,    lock_nxt;
  logic [31:0] rd;
  logic        bad;

  // Decode the word against the current register state.
  always_comb begin
    enable_nxt  = enable_r;
    irq_en_nxt  = irq_en_r;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    timeout_nxt = timeout_r;
    lock_nxt    = lock_r;
    rd          = '0;
    bad         = 1'b0;
    unique case (op_t'(item.opcode))
      OP_TICK: begin
        // A zero count never times out.
        if (enable_r && (count_r != '0)) begin
          count_nxt = count_r - 32'd1;
          if (count_r == 32'd1) begin
            timeout_nxt = 1'b1;
          end
        end
      end
      OP_READ: begin
        unique case (item.reg_index)
          REG_CTRL: begin
            rd[CTRL_EN_BIT]    = enable_r;
            rd[CTRL_INTEN_BIT] = irq_en_r;
          end
          REG_LOAD:   rd = reload_r;
          REG_COUNT:  rd = count_r;
          REG_KEY:    rd = '0;
          REG_STATUS: rd[SR_TIMEOUT_BIT] = timeout_r;
          default:    bad = 1'b1;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_index)
          REG_CTRL: begin
            if (lock_r) begin
              bad = 1'b1;
            end else begin
              enable_nxt = item.write_data[CTRL_EN_BIT];
              irq_en_nxt = item.write_data[CTRL_INTEN_BIT];
              if (item.write_data[CTRL_EN_BIT]) begin
                count_nxt = reload_r;
              end
            end
          end
          REG_LOAD: begin
            if (lock_r) begin
              bad = 1'b1;
            end else begin
              reload_nxt = item.write_data;
            end
          end
          REG_COUNT: begin
            // Read-only; the write is dropped quietly.
          end
          REG_KEY: begin
            if (item.write_data == FEED_KEY) begin
              count_nxt   = reload_r;
              timeout_nxt = 1'b0;
            end else if (item.write_data == LOCK_KEY) begin
              lock_nxt = 1'b1;
            end else begin
              bad = 1'b1;
            end
          end
          REG_STATUS: begin
            if (item.write_data[SR_TIMEOUT_BIT]) begin
              timeout_nxt = 1'b0;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      default: begin
        // Idle word: nothing changes.
      end
    endcase
  end

  // The interrupt level reflects the state after this word; read data the state before it.
  always_comb begin
    result.read_data  = rd;
    result.irq_level  = timeout_nxt & irq_en_nxt;
    result.bad_access = bad;
  end

  // Register state, updated only when the word moves to the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      irq_en_r  <= 1'b0;
      reload_r  <= '0;
      count_r   <= '0;
      timeout_r <= 1'b0;
      lock_r    <= 1'b0;
    end else if (fire) begin
      enable_r  <= enable_nxt;
      irq_en_r  <= irq_en_nxt;
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      timeout_r <= timeout_nxt;
      lock_r    <= lock_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/watchdog_timer_with_lock.sv
// Watchdog timer with a lock key, behind five 32-bit word registers.
// The input channel carries one word per access: a timer tick, a register
// read, a register write or an idle word (opcode, reg_index, write_data).
// Every input word yields exactly one result word on the output channel:
// read_data, the interrupt level after the access, and a bad_access flag.
// A word accepted into the input register is decoded against the register
// state and, once the output register is free, moves into it with the state
// update; its result is then offered from the output register until taken.
// Throughput is one word per cycle unless the receiver stalls; a tick or
// access may follow the previous one immediately, since the decode and
// register update fit in the single stage between the input and output
// registers.
// If the receiver stalls, the output register holds its word, the input
// register takes one more word, and only then is in_chan.ready dropped.
// Synchronous reset (rst_n low) empties both registers and clears all
// watchdog state: disabled, no interrupt, load and count zero, unlocked.
`default_nettype none

module watchdog_timer_with_lock
  import wdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  wdt_in_if.sink    in_chan,
  wdt_out_if.source out_chan
);

  logic        in_v_r;
  wdt_item_t   item_r;
  logic        out_v_r;
  wdt_result_t res_r;
  wdt_result_t res_nxt;
  logic        advance;

  // Move a word to the output stage when the output register is free or its word is being taken.
  assign advance       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r.opcode     <= in_chan.opcode;
      item_r.reg_index  <= in_chan.reg_index;
      item_r.write_data <= in_chan.write_data;
    end
  end

  // Decode and register state.
  wdt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .result (res_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.read_data  = res_r.read_data;
  assign out_chan.irq_level  = res_r.irq_level;
  assign out_chan.bad_access = res_r.bad_access;

  // A held input word is never overwritten while it waits.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && $stable(item_r)))
    else $error("input word lost while waiting");

  // A stalled result word keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready) |=> (out_v_r && $stable(res_r)))
    else $error("result word changed while stalled");

  // Both stages are empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!in_v_r && !out_v_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: sim/watchdog_timer_with_lock_tb.sv
`timescale 1ns / 100ps

module watchdog_timer_with_lock_tb;
  import wdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PERCENT = 38;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned STALL_CYCLES = 250;
  localparam logic [2:0]  IDX_BAD_FIRST = 3'd5;
  localparam logic [2:0]  IDX_BAD_LAST  = 3'd7;

  logic clk;
  logic rst_n;

  wdt_in_if  in_bus ();
  wdt_out_if out_bus ();

  watchdog_timer_with_lock uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Own copy of the watchdog state, advanced once per accepted word.
  logic        wd_enable;
  logic        wd_irq_en;
  logic [31:0] wd_reload;
  logic [31:0] wd_count;
  logic        wd_timeout;
  logic        wd_locked;

  wdt_result_t expected_results[$];
  wdt_result_t seen_word;
  wdt_result_t wanted_word;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_gaps_on = 1'b1;
  bit          stall_request = 1'b0;
  int unsigned stall_left = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, in case the block stops answering.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Works out the result of one word and updates the state copy.
  function automatic wdt_result_t predict_watchdog(input wdt_item_t w);
    wdt_result_t r;
    r = '0;
    case (w.opcode)
      OP_TICK: begin
        if (wd_enable && wd_count != 32'd0) begin
          wd_count = wd_count - 32'd1;
          if (wd_count == 32'd0) wd_timeout = 1'b1;
        end
      end
      OP_READ: begin
        case (w.reg_index)
          REG_CTRL: begin
            r.read_data[CTRL_EN_BIT]    = wd_enable;
            r.read_data[CTRL_INTEN_BIT] = wd_irq_en;
          end
          REG_LOAD:   r.read_data = wd_reload;
          REG_COUNT:  r.read_data = wd_count;
          REG_KEY:    ;
          REG_STATUS: r.read_data[SR_TIMEOUT_BIT] = wd_timeout;
          default:    r.bad_access = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (w.reg_index)
          REG_CTRL: begin
            if (wd_locked) begin
              r.bad_access = 1'b1;
            end else begin
              wd_enable = w.write_data[CTRL_EN_BIT];
              wd_irq_en = w.write_data[CTRL_INTEN_BIT];
              if (wd_enable) wd_count = wd_reload;
            end
          end
          REG_LOAD: begin
            if (wd_locked) r.bad_access = 1'b1;
            else wd_reload = w.write_data;
          end
          REG_COUNT: ;
          REG_KEY: begin
            if (w.write_data == FEED_KEY) begin
              wd_count   = wd_reload;
              wd_timeout = 1'b0;
            end else if (w.write_data == LOCK_KEY) begin
              wd_locked = 1'b1;
            end else begin
              r.bad_access = 1'b1;
            end
          end
          REG_STATUS: begin
            if (w.write_data[SR_TIMEOUT_BIT]) wd_timeout = 1'b0;
          end
          default: r.bad_access = 1'b1;
        endcase
      end
      default: ;
    endcase
    r.irq_level = wd_timeout && wd_irq_en;
    return r;
  endfunction

  // Offers one word, waits for it to be taken and records its expected result.
  task automatic send_word(input op_t op, input logic [2:0] idx, input logic [31:0] data);
    wdt_item_t w;
    w.opcode     = op;
    w.reg_index  = idx;
    w.write_data = data;
    while (in_gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= w.opcode;
    in_bus.reg_index  <= w.reg_index;
    in_bus.write_data <= w.write_data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expected_results.push_back(predict_watchdog(w));
  endtask

  // Draws one random word; the lock key is kept out until the lock phase.
  task automatic random_word(input bit lock_allowed, output op_t op, output logic [2:0] idx,
                             output logic [31:0] data);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) op = OP_TICK;
    else if (pick < 64) op = OP_READ;
    else if (pick < 96) op = OP_WRITE;
    else op = OP_IDLE;
    if ($urandom_range(0, 99) < 8) idx = 3'($urandom_range(IDX_BAD_FIRST, IDX_BAD_LAST));
    else idx = 3'($urandom_range(REG_CTRL, REG_STATUS));
    data = $urandom();
    if (op == OP_WRITE) begin
      case (idx)
        REG_CTRL: if ($urandom_range(0, 3) != 0) data = {30'd0, data[1:0]};
        REG_LOAD: if ($urandom_range(0, 7) != 0) data = $urandom_range(0, 24);
        REG_KEY: begin
          pick = $urandom_range(0, 99);
          if (pick < 45) data = FEED_KEY;
          else if (pick < 55 && lock_allowed) data = LOCK_KEY;
        end
        default: ;
      endcase
    end
    if (!lock_allowed && op == OP_WRITE && idx == REG_KEY && data == LOCK_KEY) data = ~data;
  endtask

  // Result side: checks each word taken and decides the next ready level.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        seen_word.read_data  = out_bus.read_data;
        seen_word.irq_level  = out_bus.irq_level;
        seen_word.bad_access = out_bus.bad_access;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Unexpected result word: read_data %h irq_level %b bad_access %b",
                     seen_word.read_data, seen_word.irq_level, seen_word.bad_access);
        end else begin
          wanted_word = expected_results.pop_front();
          if (seen_word !== wanted_word) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("Mismatch: expected rd %h irq %b bad %b, got rd %h irq %b bad %b",
                       wanted_word.read_data, wanted_word.irq_level, wanted_word.bad_access,
                       seen_word.read_data, seen_word.irq_level, seen_word.bad_access);
          end
        end
      end
      if (stall_request) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (out_gaps_on) begin
        out_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Reads straight after reset, bad indexes and the idle opcode.
  task automatic test_reset_state();
    send_word(OP_READ, REG_CTRL, 32'h0);
    send_word(OP_READ, REG_LOAD, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_COUNT, 32'h0);
    send_word(OP_READ, REG_KEY, 32'h0);
    send_word(OP_READ, REG_STATUS, 32'h0);
    send_word(OP_READ, IDX_BAD_FIRST, 32'h0);
    send_word(OP_WRITE, IDX_BAD_LAST, 32'hFFFF_FFFF);
    send_word(OP_IDLE, IDX_BAD_LAST, 32'hFFFF_FFFF);
  endtask

  // Extreme load values, enabling with zero load and the read-only count.
  task automatic test_register_extremes();
    send_word(OP_WRITE, REG_LOAD, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_LOAD, 32'h0);
    send_word(OP_WRITE, REG_LOAD, 32'h0);
    send_word(OP_WRITE, REG_CTRL, 32'h3);
    send_word(OP_TICK, REG_CTRL, 32'h0);
    send_word(OP_READ, REG_STATUS, 32'h0);
    send_word(OP_WRITE, REG_COUNT, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_COUNT, 32'h0);
  endtask

  // Count down to a timeout, then clear it by status and by the feed key.
  task automatic test_timeout_and_feed();
    send_word(OP_WRITE, REG_LOAD, 32'd2);
    send_word(OP_WRITE, REG_CTRL, 32'hFFFF_FFFF);
    send_word(OP_TICK, REG_KEY, 32'h0);
    send_word(OP_TICK, REG_KEY, 32'h0);
    send_word(OP_WRITE, REG_STATUS, 32'hFFFF_FFFE);
    send_word(OP_WRITE, REG_STATUS, 32'h1);
    send_word(OP_TICK, REG_KEY, 32'h0);
    send_word(OP_WRITE, REG_KEY, FEED_KEY);
    send_word(OP_TICK, REG_KEY, 32'h0);
    send_word(OP_TICK, REG_KEY, 32'h0);
    send_word(OP_WRITE, REG_CTRL, 32'h0);
    send_word(OP_WRITE, REG_KEY, 32'h0);
    send_word(OP_WRITE, REG_KEY, FEED_KEY);
    send_word(OP_READ, REG_COUNT, 32'h0);
  endtask

  // Random accesses while unlocked, with idling on both sides.
  task automatic test_random_mix(input int unsigned n);
    op_t         op;
    logic [2:0]  idx;
    logic [31:0] data;
    repeat (n) begin
      random_word(1'b0, op, idx, data);
      send_word(op, idx, data);
    end
  endtask

  // A long run of words with neither side idling.
  task automatic test_back_to_back(input int unsigned n);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_mix(n);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_input_backpressure();
    in_gaps_on    = 1'b0;
    stall_request = 1'b1;
    test_random_mix(24);
    in_gaps_on    = 1'b1;
  endtask

  // Lock, then locked writes, a second lock key and a feed while locked.
  task automatic test_lock();
    send_word(OP_WRITE, REG_LOAD, 32'd3);
    send_word(OP_WRITE, REG_CTRL, 32'h3);
    send_word(OP_WRITE, REG_KEY, LOCK_KEY);
    send_word(OP_WRITE, REG_CTRL, 32'h0);
    send_word(OP_WRITE, REG_LOAD, 32'd7);
    send_word(OP_WRITE, REG_KEY, LOCK_KEY);
    send_word(OP_WRITE, REG_KEY, FEED_KEY);
    send_word(OP_READ, REG_CTRL, 32'h0);
  endtask

  // Random accesses once locked; the lock key may now appear too.
  task automatic test_random_locked(input int unsigned n);
    op_t         op;
    logic [2:0]  idx;
    logic [31:0] data;
    repeat (n) begin
      random_word(1'b1, op, idx, data);
      send_word(op, idx, data);
    end
  endtask

  // Test sequence.
  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_IDLE;
    in_bus.reg_index  <= REG_CTRL;
    in_bus.write_data <= 32'h0;
    wd_enable  = 1'b0;
    wd_irq_en  = 1'b0;
    wd_reload  = 32'h0;
    wd_count   = 32'h0;
    wd_timeout = 1'b0;
    wd_locked  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_timeout_and_feed();
    test_random_mix(700);
    test_back_to_back(300);
    test_input_backpressure();
    test_random_mix(500);
    test_lock();
    test_random_locked(400);

    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
